FILE: design/rtpfu_pkg.sv
// Package for the H.264 RTP FU-A packetiser: configuration and queue entry
// types, header byte constants and emitter byte positions.
// No dependencies.
package rtpfu_pkg;

  localparam int LENGTH_BITS = 16;
  localparam int SSRC_W      = 32;
  localparam int TS_W        = 32;
  localparam int USEC_W      = 48;

  localparam logic [1:0] REG_TCP_INTERLEAVED = 2'd0;
  localparam logic [1:0] REG_HEVC_MODE       = 2'd1;
  localparam logic [1:0] REG_MAX_FRAGMENT    = 2'd2;
  localparam logic [1:0] REG_STREAM_SSRC     = 2'd3;

  localparam logic              RST_TCP   = 1'b1;
  localparam logic              RST_HEVC  = 1'b0;
  localparam logic [LENGTH_BITS-1:0] RST_MAX_FRAG = 16'd1262;
  localparam logic [SSRC_W-1:0] RST_SSRC  = 32'h0102_0304;
  localparam logic [15:0]       SEQ_RESET = 16'd1234;

  localparam logic [7:0] ILV_MAGIC   = 8'h24;
  localparam logic [7:0] ILV_CHANNEL = 8'h00;
  localparam logic [7:0] RTP_VER     = 8'h80;
  localparam logic [7:0] RTP_PT      = 8'h60;
  localparam logic [7:0] NRI_MASK    = 8'hE0;
  localparam logic [7:0] FU_A_TYPE   = 8'h1C;
  localparam logic [7:0] TYPE_MASK   = 8'h1F;
  localparam logic [7:0] FU_START    = 8'h80;
  localparam logic [7:0] FU_END      = 8'h40;
  localparam logic [LENGTH_BITS-1:0] SINGLE_OVH = 16'd12;
  localparam logic [LENGTH_BITS-1:0] FRAG_OVH   = 16'd14;

  // timestamp = floor(usec * 9 / 100), long division eight bits per stage
  localparam int DIVIDEND_W = 56;
  localparam int DIV_BITS   = 8;
  localparam int DIV_STAGES = DIVIDEND_W / DIV_BITS;
  localparam int REM_W      = 7;
  localparam logic [REM_W:0] TS_DIVISOR = 8'd100;

  localparam int POS_W = 5;
  localparam logic [POS_W-1:0] POS_PREFIX = 5'd0;
  localparam logic [POS_W-1:0] POS_LEN_HI = 5'd2;
  localparam logic [POS_W-1:0] POS_LEN_LO = 5'd3;
  localparam logic [POS_W-1:0] POS_RTP    = 5'd4;
  localparam logic [POS_W-1:0] POS_PT     = 5'd5;
  localparam logic [POS_W-1:0] POS_SEQ_HI = 5'd6;
  localparam logic [POS_W-1:0] POS_SEQ_LO = 5'd7;
  localparam logic [POS_W-1:0] POS_TS3    = 5'd8;
  localparam logic [POS_W-1:0] POS_TS2    = 5'd9;
  localparam logic [POS_W-1:0] POS_TS1    = 5'd10;
  localparam logic [POS_W-1:0] POS_TS0    = 5'd11;
  localparam logic [POS_W-1:0] POS_SSRC3  = 5'd12;
  localparam logic [POS_W-1:0] POS_SSRC2  = 5'd13;
  localparam logic [POS_W-1:0] POS_SSRC1  = 5'd14;
  localparam logic [POS_W-1:0] POS_SSRC0  = 5'd15;
  localparam logic [POS_W-1:0] POS_FU_IND = 5'd16;
  localparam logic [POS_W-1:0] POS_FU_HDR = 5'd17;
  localparam logic [POS_W-1:0] POS_DATA   = 5'd18;
  localparam logic [POS_W-1:0] POS_CHAN   = 5'd1;

  typedef struct packed {
    logic                   tcp_interleaved;
    logic                   hevc_mode;
    logic [LENGTH_BITS-1:0] max_fragment;
    logic [SSRC_W-1:0]      stream_ssrc;
  } cfg_t;

  typedef struct packed {
    logic                   first;
    logic                   hdr;
    logic                   fu;
    logic                   emit;
    logic                   pend;
    logic [LENGTH_BITS-1:0] plen;
    logic [7:0]             fu_ind;
    logic [7:0]             fu_hdr;
    logic [7:0]             data;
    logic [TS_W-1:0]        ts;
  } entry_t;

  typedef struct packed {
    logic [REM_W-1:0]   rem;
    logic [DIV_BITS-1:0] quo;
  } div_step_t;

  function automatic div_step_t div_step(input logic [REM_W-1:0] rem_in,
                                         input logic [DIV_BITS-1:0] bits);
    div_step_t    res;
    logic [REM_W:0] part;
    res.rem = rem_in;
    res.quo = '0;
    for (int i = DIV_BITS - 1; i >= 0; i--) begin
      part = {res.rem, bits[i]};
      if (part >= TS_DIVISOR) begin
        part       = part - TS_DIVISOR;
        res.quo[i] = 1'b1;
      end
      res.rem = part[REM_W-1:0];
    end
    return res;
  endfunction

endpackage

FILE: design/rtpfu_if.sv
// Handshake interfaces of the RTP packetiser: NAL byte input, packet byte output.
// Depends on rtpfu_pkg.
interface rtpfu_nal_if import rtpfu_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [7:0]             nal_byte;
  logic [LENGTH_BITS-1:0] nal_length;
  logic [USEC_W-1:0]      capture_usec;
  logic                   unit_end;

  modport source (output valid, nal_byte, nal_length, capture_usec, unit_end, input ready);
  modport sink (input valid, nal_byte, nal_length, capture_usec, unit_end, output ready);
endinterface

interface rtpfu_rtp_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       packet_end;
  logic       run_last;

  modport source (output valid, out_byte, packet_end, run_last, input ready);
  modport sink (input valid, out_byte, packet_end, run_last, output ready);
endinterface

FILE: design/h264_rtp_fu_a_packetizer.sv
// Top level of the H.264 RTP FU-A packetiser: configuration registers, front
// end, entry queue and back end. Depends on rtpfu_pkg, rtpfu_if and the rtpfu modules.
//
// Usage:
//   nal  - one NAL unit byte per beat with the unit's length, capture time in
//          microseconds and an end-of-unit flag.
//   rtp  - packet stream, one byte per beat; packet_end marks the last byte of
//          each packet, run_last the last byte caused by an input byte.
//   cfg  - write enable, register index and data; write only while idle.
// Throughput: one input beat per cycle while the output keeps pace. A byte
// that opens a packet yields 13 to 19 output bytes (prefix, RTP header, FU
// bytes), the header byte of a fragmented unit none, other bytes one; the
// back end's single output register sets this. Path from input beat to first
// output byte: the input register, the seven-stage timestamp divider, the queue
// and the output register. Reset: clears unit tracking, empties pipeline and queue,
// restores register defaults and the sequence counter (1234). A stalled receiver
// holds the output beat; the queue then fills and the input ready drops.
module h264_rtp_fu_a_packetizer import rtpfu_pkg::*; #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data,
  rtpfu_nal_if.sink   nal,
  rtpfu_rtp_if.source rtp
);

  cfg_t   cfg;
  logic   q_ready;
  logic   q_push;
  entry_t q_entry;
  logic   head_valid;
  entry_t head;
  logic   pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.tcp_interleaved <= RST_TCP;
      cfg.hevc_mode       <= RST_HEVC;
      cfg.max_fragment    <= RST_MAX_FRAG;
      cfg.stream_ssrc     <= RST_SSRC;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_TCP_INTERLEAVED: cfg.tcp_interleaved <= cfg_data[0];
        REG_HEVC_MODE:       cfg.hevc_mode       <= cfg_data[0];
        REG_MAX_FRAGMENT:    cfg.max_fragment    <= cfg_data[LENGTH_BITS-1:0];
        REG_STREAM_SSRC:     cfg.stream_ssrc     <= cfg_data[SSRC_W-1:0];
      endcase
    end
  end

  rtpfu_front u_front (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .nal     (nal),
    .q_ready (q_ready),
    .q_push  (q_push),
    .q_entry (q_entry)
  );

  rtpfu_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .din        (q_entry),
    .ready      (q_ready),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop)
  );

  rtpfu_back u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .rtp        (rtp)
  );

endmodule

FILE: design/rtpfu_front.sv
// Front end: accepts NAL bytes, tracks unit and fragment position, classifies
// each byte and computes the RTP timestamp in a pipelined divider. Uses rtpfu_pkg.
module rtpfu_front import rtpfu_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  cfg_t         cfg,
  rtpfu_nal_if.sink    nal,
  input  logic         q_ready,
  output logic         q_push,
  output entry_t       q_entry
);

  logic [LENGTH_BITS-1:0] byte_position;
  logic [LENGTH_BITS-1:0] fragment_fill;
  logic [LENGTH_BITS-1:0] unit_len;
  logic [LENGTH_BITS-1:0] frag_size;
  logic [7:0]             saved_nal_header;
  logic                   fragmenting;

  logic                   stg_v [0:DIV_STAGES];
  entry_t                 stg_e [0:DIV_STAGES];
  logic [REM_W-1:0]       stg_r [0:DIV_STAGES];
  logic [DIVIDEND_W-1:0]  stg_n [0:DIV_STAGES];

  logic                   adv;
  logic                   take;
  logic                   first;
  logic [LENGTH_BITS-1:0] len_in;
  logic [LENGTH_BITS-1:0] fs_in;
  logic [LENGTH_BITS-1:0] ul_c;
  logic [LENGTH_BITS-1:0] fs_c;
  logic                   frag_c;
  logic [7:0]             nh_c;
  logic [LENGTH_BITS-1:0] ff_c;
  logic [LENGTH_BITS:0]   pos_inc;
  logic [LENGTH_BITS:0]   ff_inc;
  logic                   last_byte;
  logic                   frag_end;
  logic [LENGTH_BITS-1:0] rem;
  logic [LENGTH_BITS-1:0] size;
  entry_t                 ent;
  logic [DIVIDEND_W-1:0]  dividend;
  div_step_t              steps [1:DIV_STAGES];
  entry_t                 stg_nx [1:DIV_STAGES];

  assign adv       = !stg_v[DIV_STAGES] || q_ready;
  assign nal.ready = adv;
  assign take      = nal.valid && adv;
  assign q_push    = stg_v[DIV_STAGES] && q_ready;
  assign q_entry   = stg_e[DIV_STAGES];

  always_comb begin
    first   = (byte_position == '0);
    len_in  = (nal.nal_length == '0) ? LENGTH_BITS'(1) : nal.nal_length;
    fs_in   = (cfg.max_fragment == '0) ? LENGTH_BITS'(1) : cfg.max_fragment;
    ul_c    = first ? len_in : unit_len;
    fs_c    = first ? fs_in : frag_size;
    frag_c  = first ? (!cfg.hevc_mode && (len_in > fs_in)) : fragmenting;
    nh_c    = first ? nal.nal_byte : saved_nal_header;
    ff_c    = first ? '0 : fragment_fill;
    pos_inc = {1'b0, byte_position} + (LENGTH_BITS+1)'(1);
    ff_inc  = {1'b0, ff_c} + (LENGTH_BITS+1)'(1);
    last_byte = nal.unit_end || (pos_inc >= {1'b0, ul_c});
    frag_end  = last_byte || (ff_inc >= {1'b0, fs_c});
    rem     = ul_c - byte_position;
    size    = (rem < fs_c) ? rem : fs_c;

    ent        = '0;
    ent.first  = first;
    ent.data   = nal.nal_byte;
    ent.fu_ind = (nh_c & NRI_MASK) | FU_A_TYPE;
    if (byte_position == LENGTH_BITS'(1)) begin
      ent.fu_hdr = FU_START | (nh_c & TYPE_MASK);
    end else if (rem <= fs_c) begin
      ent.fu_hdr = FU_END | (nh_c & TYPE_MASK);
    end else begin
      ent.fu_hdr = nh_c & TYPE_MASK;
    end
    if (frag_c) begin
      ent.hdr  = !first && (ff_c == '0);
      ent.fu   = !first && (ff_c == '0);
      ent.emit = !first;
      ent.pend = frag_end;
      ent.plen = size + FRAG_OVH;
    end else begin
      ent.hdr  = first;
      ent.fu   = 1'b0;
      ent.emit = 1'b1;
      ent.pend = last_byte;
      ent.plen = ul_c + SINGLE_OVH;
    end

    dividend = DIVIDEND_W'({nal.capture_usec, 3'b000}) + DIVIDEND_W'(nal.capture_usec);
    for (int k = 1; k <= DIV_STAGES; k++) begin
      steps[k]     = div_step(stg_r[k-1], stg_n[k-1][DIVIDEND_W-1 -: DIV_BITS]);
      stg_nx[k]    = stg_e[k-1];
      stg_nx[k].ts = {stg_e[k-1].ts[TS_W-DIV_BITS-1:0], steps[k].quo};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position <= '0;
      fragment_fill <= '0;
      fragmenting   <= 1'b0;
      for (int k = 0; k <= DIV_STAGES; k++) begin
        stg_v[k] <= 1'b0;
      end
    end else begin
      if (take) begin
        if (first) begin
          unit_len         <= len_in;
          frag_size        <= fs_in;
          fragmenting      <= frag_c;
          saved_nal_header <= nal.nal_byte;
        end
        if (last_byte) begin
          byte_position <= '0;
          fragment_fill <= '0;
        end else begin
          byte_position <= pos_inc[LENGTH_BITS-1:0];
          fragment_fill <= (frag_c && !first && !frag_end) ? ff_inc[LENGTH_BITS-1:0] : '0;
        end
      end
      if (adv) begin
        stg_v[0] <= take;
        for (int k = 1; k <= DIV_STAGES; k++) begin
          stg_v[k] <= stg_v[k-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      stg_e[0] <= ent;
      stg_r[0] <= '0;
      stg_n[0] <= dividend;
      for (int k = 1; k <= DIV_STAGES; k++) begin
        stg_e[k] <= stg_nx[k];
        stg_r[k] <= steps[k].rem;
        stg_n[k] <= {stg_n[k-1][DIVIDEND_W-DIV_BITS-1:0], DIV_BITS'(0)};
      end
    end
  end

endmodule

FILE: design/rtpfu_queue.sv
// Short queue of classified entries between front and back end.
// Uses rtpfu_pkg for the entry type.
module rtpfu_queue import rtpfu_pkg::*; #(
  parameter int DEPTH = 4
) (
  input  logic   clk,
  input  logic   rst,
  input  logic   push,
  input  entry_t din,
  output logic   ready,
  output logic   head_valid,
  output entry_t head,
  input  logic   pop
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  entry_t             slots [0:DEPTH-1];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [CNT_W-1:0]   count;
  logic               do_pop;

  assign ready      = (count != CNT_W'(DEPTH));
  assign head_valid = (count != '0);
  assign head       = slots[rd_ptr];
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !do_pop) begin
        count <= count + CNT_W'(1);
      end else if (!push && do_pop) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= din;
    end
  end

endmodule

FILE: design/rtpfu_back.sv
// Back end: walks each queued entry through prefix, RTP header, FU bytes and
// payload into a registered output beat. Uses rtpfu_pkg and rtpfu_rtp_if.
module rtpfu_back import rtpfu_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  cfg_t        cfg,
  input  logic        head_valid,
  input  entry_t      head,
  output logic        pop,
  rtpfu_rtp_if.source rtp
);

  logic             ov;
  logic [7:0]       obyte;
  logic             opend;
  logic             olast;
  logic             busy;
  logic [POS_W-1:0] pos;
  logic [15:0]      seq;
  logic [TS_W-1:0]  ts_reg;

  logic             can_load;
  logic             fire;
  logic [POS_W-1:0] start_pos;
  logic [POS_W-1:0] eff_pos;
  logic [POS_W-1:0] next_pos;
  logic [TS_W-1:0]  ts_cur;
  logic [7:0]       byte_sel;

  assign rtp.valid      = ov;
  assign rtp.out_byte   = obyte;
  assign rtp.packet_end = opend;
  assign rtp.run_last   = olast;

  always_comb begin
    can_load  = !ov || rtp.ready;
    start_pos = head.hdr ? (cfg.tcp_interleaved ? POS_PREFIX : POS_RTP) : POS_DATA;
    eff_pos   = busy ? pos : start_pos;
    fire      = head_valid && head.emit && can_load;
    pop       = head_valid && (!head.emit || (can_load && eff_pos == POS_DATA));
    ts_cur    = head.first ? head.ts : ts_reg;
    if (eff_pos == POS_SSRC0) begin
      next_pos = head.fu ? POS_FU_IND : POS_DATA;
    end else begin
      next_pos = eff_pos + POS_W'(1);
    end
    unique case (eff_pos)
      POS_PREFIX: byte_sel = ILV_MAGIC;
      POS_CHAN:   byte_sel = ILV_CHANNEL;
      POS_LEN_HI: byte_sel = head.plen[15:8];
      POS_LEN_LO: byte_sel = head.plen[7:0];
      POS_RTP:    byte_sel = RTP_VER;
      POS_PT:     byte_sel = RTP_PT;
      POS_SEQ_HI: byte_sel = seq[15:8];
      POS_SEQ_LO: byte_sel = seq[7:0];
      POS_TS3:    byte_sel = ts_cur[31:24];
      POS_TS2:    byte_sel = ts_cur[23:16];
      POS_TS1:    byte_sel = ts_cur[15:8];
      POS_TS0:    byte_sel = ts_cur[7:0];
      POS_SSRC3:  byte_sel = cfg.stream_ssrc[31:24];
      POS_SSRC2:  byte_sel = cfg.stream_ssrc[23:16];
      POS_SSRC1:  byte_sel = cfg.stream_ssrc[15:8];
      POS_SSRC0:  byte_sel = cfg.stream_ssrc[7:0];
      POS_FU_IND: byte_sel = head.fu_ind;
      POS_FU_HDR: byte_sel = head.fu_hdr;
      POS_DATA:   byte_sel = head.data;
      default:    byte_sel = 8'h00;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ov   <= 1'b0;
      busy <= 1'b0;
      pos  <= POS_PREFIX;
      seq  <= SEQ_RESET;
    end else begin
      if (fire) begin
        ov <= 1'b1;
      end else if (rtp.ready) begin
        ov <= 1'b0;
      end
      if (fire) begin
        busy <= (eff_pos != POS_DATA);
        pos  <= next_pos;
        if (!busy && head.hdr) begin
          seq <= seq + 16'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      obyte <= byte_sel;
      opend <= (eff_pos == POS_DATA) && head.pend;
      olast <= (eff_pos == POS_DATA);
    end
    if (pop && head.first) begin
      ts_reg <= head.ts;
    end
  end

endmodule

FILE: design/rtpfu_chk.sv
// Port checker for the RTP packetiser output channel, bound to the top level.
// Depends on h264_rtp_fu_a_packetizer.
module rtpfu_chk (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_byte,
  input logic       packet_end,
  input logic       run_last
);

  a_valid_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("output beat dropped while stalled");

  a_payload_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(out_byte) && $stable(packet_end) && $stable(run_last))
    else $error("output beat changed while stalled");

  a_end_is_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && packet_end |-> run_last)
    else $error("packet end on a beat that is not the last of its input byte");

  a_reset_idle: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> !out_valid)
    else $error("output valid straight after reset");

endmodule

bind h264_rtp_fu_a_packetizer rtpfu_chk u_chk (
  .clk        (clk),
  .rst        (rst),
  .out_valid  (rtp.valid),
  .out_ready  (rtp.ready),
  .out_byte   (rtp.out_byte),
  .packet_end (rtp.packet_end),
  .run_last   (rtp.run_last)
);

FILE: bench/h264_rtp_fu_a_packetizer_test.sv
// Self-checking bench for h264_rtp_fu_a_packetizer: directed table then random NAL units,
// every packet stream beat checked against an in-bench packetiser predictor.
// Depends on rtpfu_pkg, rtpfu_if and the design sources.
module h264_rtp_fu_a_packetizer_test;
  import rtpfu_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [7:0] data;
    logic       pend;
    logic       last;
  } stream_beat_t;

  typedef struct {
    logic [7:0]        b;
    logic [15:0]       len;
    logic [USEC_W-1:0] usec;
    logic              uend;
    int                ph;
    int                n;
  } nal_row_t;

  typedef struct {
    logic        tcp;
    logic        hevc;
    logic [15:0] mf;
    logic [31:0] ssrc;
  } cfg_pick_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = REG_TCP_INTERLEAVED;
  logic [31:0] cfg_data = '0;

  rtpfu_nal_if nal ();
  rtpfu_rtp_if rtp ();

  h264_rtp_fu_a_packetizer uut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .nal       (nal),
    .rtp       (rtp)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // predictor state and register copy
  logic              cfg_tcp     = RST_TCP;
  logic              cfg_hevc    = RST_HEVC;
  logic [15:0]       cfg_maxfrag = RST_MAX_FRAG;
  logic [31:0]       cfg_ssrc    = RST_SSRC;
  logic [15:0]       seq_no      = SEQ_RESET;
  logic [15:0]       unit_pos    = '0;
  int unsigned       frag_used   = 0;
  logic [7:0]        unit_hdr    = '0;
  logic [31:0]       cur_ts      = '0;
  logic              splitting   = 1'b0;
  int unsigned       unit_size   = 0;
  int unsigned       frag_limit  = 0;

  stream_beat_t stream_due[$];
  stream_beat_t head;
  int           mismatches = 0;
  logic         calm = 1'b0;
  int           stall_left = 0;
  int           stall_roll;

  function automatic void note_mismatch(string msg);
    mismatches++;
    if (mismatches <= 10) $display("MISMATCH: %s", msg);
  endfunction

  function automatic void emit(logic [7:0] d, logic pe);
    stream_due.push_back('{data: d, pend: pe, last: 1'b0});
  endfunction

  function automatic void emit_headers(int unsigned plen);
    logic [15:0] plen16;
    plen16 = plen[15:0];
    seq_no = seq_no + 16'd1;
    if (cfg_tcp) begin
      emit(ILV_MAGIC, 1'b0);
      emit(ILV_CHANNEL, 1'b0);
      emit(plen16[15:8], 1'b0);
      emit(plen16[7:0], 1'b0);
    end
    emit(RTP_VER, 1'b0);
    emit(RTP_PT, 1'b0);
    emit(seq_no[15:8], 1'b0);
    emit(seq_no[7:0], 1'b0);
    emit(cur_ts[31:24], 1'b0);
    emit(cur_ts[23:16], 1'b0);
    emit(cur_ts[15:8], 1'b0);
    emit(cur_ts[7:0], 1'b0);
    emit(cfg_ssrc[31:24], 1'b0);
    emit(cfg_ssrc[23:16], 1'b0);
    emit(cfg_ssrc[15:8], 1'b0);
    emit(cfg_ssrc[7:0], 1'b0);
  endfunction

  // packet bytes caused by one NAL byte; returns how many
  function automatic int packetize_byte(logic [7:0] b, logic [15:0] len,
                                        logic [USEC_W-1:0] usec, logic uend);
    int          before_n;
    logic        closing;
    logic        pe;
    int unsigned rem;
    int unsigned chunk;
    logic [7:0]  fu_hdr;
    logic [63:0] scaled;
    before_n = stream_due.size();
    if (unit_pos == 0) begin
      unit_size  = (len == 0) ? 1 : len;
      scaled     = ({16'd0, usec} * 64'd90) / 64'd1000;
      cur_ts     = scaled[31:0];
      frag_limit = (cfg_maxfrag == 0) ? 1 : cfg_maxfrag;
      splitting  = !cfg_hevc && (unit_size > frag_limit);
      unit_hdr   = b;
      frag_used  = 0;
    end
    closing = uend || (int'(unit_pos) + 1 >= unit_size);
    if (!splitting) begin
      if (unit_pos == 0) emit_headers(unit_size + 12);
      emit(b, closing);
    end else if (unit_pos != 0) begin
      if (frag_used == 0) begin
        rem   = unit_size - unit_pos;
        chunk = (rem < frag_limit) ? rem : frag_limit;
        emit_headers(chunk + 14);
        emit((unit_hdr & NRI_MASK) | FU_A_TYPE, 1'b0);
        if (unit_pos == 1) fu_hdr = FU_START | (unit_hdr & TYPE_MASK);
        else if (rem <= frag_limit) fu_hdr = FU_END | (unit_hdr & TYPE_MASK);
        else fu_hdr = unit_hdr & TYPE_MASK;
        emit(fu_hdr, 1'b0);
      end
      frag_used++;
      pe = closing || (frag_used >= frag_limit);
      if (pe) frag_used = 0;
      emit(b, pe);
    end
    if (closing) begin
      unit_pos  = '0;
      frag_used = 0;
      splitting = 1'b0;
    end else begin
      unit_pos = unit_pos + 16'd1;
    end
    if (stream_due.size() > before_n) stream_due[stream_due.size()-1].last = 1'b1;
    return stream_due.size() - before_n;
  endfunction

  function automatic int pick_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  task automatic send_nal_byte(input logic [7:0] b, input logic [15:0] len,
                               input logic [USEC_W-1:0] usec, input logic uend,
                               output int made);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      nal.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    nal.valid        <= 1'b1;
    nal.nal_byte     <= b;
    nal.nal_length   <= len;
    nal.capture_usec <= usec;
    nal.unit_end     <= uend;
    @(posedge clk);
    while (!nal.ready) @(posedge clk);
    made = packetize_byte(b, len, usec, uend);
  endtask

  task automatic settle();
    nal.valid <= 1'b0;
    while (stream_due.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
  endtask

  task automatic set_config(input cfg_pick_t c);
    write_reg(REG_TCP_INTERLEAVED, {31'd0, c.tcp});
    write_reg(REG_HEVC_MODE, {31'd0, c.hevc});
    write_reg(REG_MAX_FRAGMENT, {16'd0, c.mf});
    write_reg(REG_STREAM_SSRC, c.ssrc);
    cfg_we      <= 1'b0;
    cfg_tcp     = c.tcp;
    cfg_hevc    = c.hevc;
    cfg_maxfrag = c.mf;
    cfg_ssrc    = c.ssrc;
  endtask

  cfg_pick_t presets [4] = '{
    '{RST_TCP, RST_HEVC, RST_MAX_FRAG, RST_SSRC},
    '{1'b0, 1'b0, 16'd0, 32'hFFFF_FFFF},
    '{1'b1, 1'b1, 16'd65521, 32'h0000_0000},
    '{1'b1, 1'b0, 16'd65521, 32'h8000_0001}
  };

  nal_row_t directed [17] = '{
    '{8'h00, 16'd1,     48'd0,               1'b1, 0, 17},
    '{8'hFF, 16'd0,     48'hFFFF_FFFF_FFFF,  1'b0, 0, 17},
    '{8'h65, 16'd2,     48'd12345,           1'b0, 0, 17},
    '{8'hAA, 16'd2,     48'd12345,           1'b1, 0, 1},
    '{8'h7C, 16'd4,     48'd1000,            1'b0, 1, 0},
    '{8'h01, 16'd4,     48'd1000,            1'b0, 1, 15},
    '{8'h55, 16'd4,     48'd1000,            1'b0, 1, 15},
    '{8'h80, 16'd4,     48'd1000,            1'b1, 1, 15},
    '{8'h5C, 16'd2,     48'd777,             1'b0, 1, 0},
    '{8'h33, 16'd2,     48'd777,             1'b1, 1, 15},
    '{8'h41, 16'd65535, 48'd5,               1'b0, 1, 0},
    '{8'h9D, 16'd65535, 48'd5,               1'b1, 1, 15},
    '{8'hE5, 16'd65530, 48'h1234_5678_9ABC,  1'b0, 2, 17},
    '{8'h11, 16'd65530, 48'h1234_5678_9ABC,  1'b1, 2, 1},
    '{8'hFC, 16'd65535, 48'h8000_0000_0000,  1'b0, 3, 0},
    '{8'h01, 16'd65535, 48'h8000_0000_0000,  1'b0, 3, 19},
    '{8'h02, 16'd65535, 48'h8000_0000_0000,  1'b1, 3, 1}
  };

  always @(posedge clk) begin
    if (stall_left > 0) begin
      rtp.ready  <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (calm) begin
      rtp.ready <= 1'b1;
    end else begin
      stall_roll = $urandom_range(0, 99);
      if (stall_roll < 70) begin
        rtp.ready <= 1'b1;
      end else if (stall_roll < 95) begin
        rtp.ready  <= 1'b0;
        stall_left <= $urandom_range(0, 2);
      end else begin
        rtp.ready  <= 1'b0;
        stall_left <= $urandom_range(10, 40);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && rtp.valid && rtp.ready) begin
      if (stream_due.size() == 0) begin
        note_mismatch($sformatf("unexpected beat: byte %h end %b last %b",
                                rtp.out_byte, rtp.packet_end, rtp.run_last));
      end else begin
        head = stream_due.pop_front();
        if (rtp.out_byte !== head.data || rtp.packet_end !== head.pend ||
            rtp.run_last !== head.last)
          note_mismatch($sformatf("beat: expected byte %h end %b last %b, got %h %b %b",
                                  head.data, head.pend, head.last,
                                  rtp.out_byte, rtp.packet_end, rtp.run_last));
      end
    end
  end

  initial begin
    #50_000_000;
    $display("h264_rtp_fu_a_packetizer regression: fail");
    $finish;
  end

  initial begin
    int                cur_ph;
    int                made;
    int                sent;
    int                shape;
    int                span;
    int                fsz;
    logic [15:0]       stated;
    logic [15:0]       lenf;
    logic [15:0]       mf;
    logic [USEC_W-1:0] usec;
    logic              endf;
    cfg_pick_t         pick;

    nal.valid        = 1'b0;
    nal.nal_byte     = '0;
    nal.nal_length   = '0;
    nal.capture_usec = '0;
    nal.unit_end     = 1'b0;
    rtp.ready        = 1'b0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    cur_ph = 0;
    for (int i = 0; i < $size(directed); i++) begin
      if (directed[i].ph != cur_ph) begin
        settle();
        cur_ph = directed[i].ph;
        set_config(presets[cur_ph]);
      end
      send_nal_byte(directed[i].b, directed[i].len, directed[i].usec,
                    directed[i].uend, made);
      if (directed[i].n >= 0 && made != directed[i].n)
        note_mismatch($sformatf("row %0d: expected %0d beats, predictor gave %0d",
                                i, directed[i].n, made));
    end

    for (int ph = 0; ph < 6; ph++) begin
      settle();
      case (ph)
        0: mf = 16'd1;
        1: mf = 16'($urandom_range(2, 12));
        2: mf = 16'd0;
        3: mf = 16'($urandom_range(3, 20));
        4: mf = 16'd65535;
        default: mf = 16'($urandom_range(2, 8));
      endcase
      pick.tcp  = (ph == 0) ? 1'b0 : 1'($urandom);
      pick.hevc = (ph == 3);
      pick.mf   = mf;
      pick.ssrc = $urandom;
      set_config(pick);
      calm = (ph == 2);
      sent = 0;
      while (sent < 70) begin
        shape = $urandom_range(0, 99);
        usec  = {16'($urandom), 32'($urandom)};
        fsz   = (mf == 0) ? 1 : mf;
        span  = $urandom_range(1, (3 * fsz + 2 > 40) ? 40 : 3 * fsz + 2);
        stated = 16'(span);
        if (shape >= 75 && shape < 85) begin
          stated = 16'($urandom_range(7, 65535));
          span   = $urandom_range(1, 6);
        end else if (shape >= 93) begin
          stated = '0;
          span   = 1;
        end
        for (int k = 0; k < span; k++) begin
          lenf = (shape >= 85 && shape < 93 && k > 0) ? 16'($urandom) : stated;
          if (shape >= 85 && shape < 93) endf = 1'b0;
          else if (shape >= 93) endf = 1'($urandom);
          else endf = (k == span - 1);
          send_nal_byte(8'($urandom), lenf, usec, endf, made);
          sent++;
        end
      end
    end

    calm = 1'b0;
    settle();
    if (mismatches == 0) begin
      $display("h264_rtp_fu_a_packetizer regression: pass");
    end else begin
      $display("h264_rtp_fu_a_packetizer regression: fail");
    end
    $finish;
  end

endmodule
